FILE: hw/rtl/esle_pkg.sv
// Shared widths, command and status codes, and record types for the episode store.
// No dependencies; every other file of the block imports this package.
package esle_pkg;

	localparam int ID_W     = 64;
	localparam int TIME_W   = 64;
	localparam int CNT_W    = 32;
	localparam int CMD_W    = 2;
	localparam int IDX_W    = 6;
	localparam int STATUS_W = 2;
	localparam int CAP_W    = 7;
	localparam int STORED_W = 7;

	// Command codes carried in the request word.
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RECALL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

	// Status codes carried in the response word.
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 2'd2;

	// Capacity register value after reset.
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// Saturation value of the recall and eviction counters.
	localparam logic [CNT_W-1:0] CNT_SAT = '1;

	// One stored episode record.
	typedef struct packed {
		logic [ID_W-1:0]   owner_id;
		logic [TIME_W-1:0] observed_time;
		logic [CNT_W-1:0]  recalls;
		logic [TIME_W-1:0] last_recall;
	} episode_t;

	// One response word.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                did_evict;
		logic [ID_W-1:0]     evicted_ledger_id;
		logic [STORED_W-1:0] stored_count;
		logic [ID_W-1:0]     entry_ledger_id;
		logic [TIME_W-1:0]   entry_observed_time;
		logic [CNT_W-1:0]    entry_recall_count;
		logic [TIME_W-1:0]   entry_last_recall;
		logic [CNT_W-1:0]    total_evictions;
	} result_t;

endpackage

FILE: hw/rtl/esle_if.sv
// Valid/ready channel interfaces for the episode store: request and response.
// Depends on esle_pkg for the field widths.
interface esle_req_if;
	import esle_pkg::*;

	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [IDX_W-1:0]    entry_index;
	logic [ID_W-1:0]     new_ledger_id;
	logic [TIME_W-1:0]   new_observed_time;
	logic [TIME_W-1:0]   recall_time;

	modport source (
		output valid, cmd, entry_index, new_ledger_id, new_observed_time, recall_time,
		input  ready
	);
	modport sink (
		input  valid, cmd, entry_index, new_ledger_id, new_observed_time, recall_time,
		output ready
	);
endinterface

interface esle_rsp_if;
	import esle_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                did_evict;
	logic [ID_W-1:0]     evicted_ledger_id;
	logic [STORED_W-1:0] stored_count;
	logic [ID_W-1:0]     entry_ledger_id;
	logic [TIME_W-1:0]   entry_observed_time;
	logic [CNT_W-1:0]    entry_recall_count;
	logic [TIME_W-1:0]   entry_last_recall;
	logic [CNT_W-1:0]    total_evictions;

	modport source (
		output valid, status, did_evict, evicted_ledger_id, stored_count, entry_ledger_id,
			entry_observed_time, entry_recall_count, entry_last_recall, total_evictions,
		input  ready
	);
	modport sink (
		input  valid, status, did_evict, evicted_ledger_id, stored_count, entry_ledger_id,
			entry_observed_time, entry_recall_count, entry_last_recall, total_evictions,
		output ready
	);
endinterface

FILE: hw/rtl/episode_store_least_recalled_evict.sv
// Episode store with least-recalled replacement: top level, sequencer and record memory.
// Depends on esle_pkg and on the channel interfaces in esle_if.sv.
//
// Usage: the req channel takes one command word (insert, recall or read); the rsp
// channel returns exactly one result word per command. The capacity register is
// written through cfg_wr_en/cfg_wr_data; the user must write it only while the block
// is idle, since the block itself does not enforce this. The block works on one
// command at a time and drops req.ready from acceptance until its result is placed
// in the output register. An insert into a full store scans all N stored records
// through one compare unit, one per memory read, then moves the records after the
// victim down one place, one per cycle, and then appends. The record memory has a
// single read port.
// The output register holds a finished result while the receiver stalls; the
// next command is accepted meanwhile and completes into the register once the
// waiting result has been taken.
// Reset empties the store, clears the eviction counter and sets capacity to 64;
// the record memory itself is not cleared and needs no clearing pass.
module episode_store_least_recalled_evict #(
	parameter int MAX_EPISODES = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	esle_req_if.sink                  req,
	esle_rsp_if.source                rsp,
	input  logic                      cfg_wr_en,
	input  logic [esle_pkg::CAP_W-1:0] cfg_wr_data
);
	import esle_pkg::*;

	localparam int AW    = $clog2(MAX_EPISODES);
	localparam int CW    = $clog2(MAX_EPISODES + 1);
	localparam int CMPW  = (CW > CAP_W) ? CW : CAP_W;
	localparam int KEY_W = CNT_W + TIME_W + ID_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_EPISODES);

	typedef enum logic [3:0] {
		S_IDLE,
		S_FETCH,
		S_RCL,
		S_SCAN,
		S_SCEND,
		S_SHIFT,
		S_SHEND,
		S_APPEND,
		S_DONE
	} state_t;

	// Control and working registers.
	state_t               state_q;
	logic [CAP_W-1:0]     cap_q;
	logic [CW-1:0]        count_q;
	logic [CNT_W-1:0]     evict_q;
	logic [CMD_W-1:0]     cmd_q;
	logic [AW-1:0]        idx_q;
	logic                 rd_hit_q;
	logic                 did_ev_q;
	logic [STATUS_W-1:0]  status_q;
	logic [ID_W-1:0]      new_id_q;
	logic [TIME_W-1:0]    new_obs_q;
	logic [TIME_W-1:0]    rtime_q;
	logic [CW-1:0]        p_q;
	logic [CW-1:0]        r_q;
	logic                 cv_s1;
	logic [AW-1:0]        ci_s1;
	logic                 wv_s1;
	logic [AW-1:0]        wa_s1;
	logic [KEY_W-1:0]     best_key_q;
	logic [AW-1:0]        victim_q;
	logic                 out_valid_q;
	result_t              out_q;

	// Record memory.
	episode_t             store_q [MAX_EPISODES];
	episode_t             rdata_q;
	logic [AW-1:0]        raddr;
	logic                 mem_we;
	logic [AW-1:0]        mem_wa;
	episode_t             mem_wd;

	logic [CMPW-1:0]      cap_w;
	logic [CW-1:0]        cap_eff;
	logic                 idx_ok;
	logic                 req_fire;
	logic                 out_free;
	logic                 out_load;
	logic [KEY_W-1:0]     key_rd;
	logic                 scan_win;
	logic [AW-1:0]        victim_nx;
	logic [CW-1:0]        r_prev;
	logic [CNT_W-1:0]     cnt_inc;

	// Effective capacity: zero acts as one, values above the store size clamp.
	always_comb begin
		cap_w = CMPW'(cap_q);
		if (cap_q == '0) begin
			cap_eff = CW'(1);
		end else if (cap_w > CMPW'(MAX_EPISODES)) begin
			cap_eff = MAX_CNT;
		end else begin
			cap_eff = CW'(cap_w);
		end
	end

	assign idx_ok   = CMPW'(req.entry_index) < CMPW'(count_q);
	assign req_fire = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign out_load = (state_q == S_DONE) && out_free;

	// Shared compare unit: the record just read against the best victim so far.
	assign key_rd    = {rdata_q.recalls, rdata_q.observed_time, rdata_q.owner_id};
	assign scan_win  = cv_s1 && ((ci_s1 == '0) || (key_rd < best_key_q));
	assign victim_nx = scan_win ? ci_s1 : victim_q;
	assign r_prev    = r_q - CW'(1);
	assign cnt_inc   = (rdata_q.recalls == CNT_SAT) ? rdata_q.recalls
		: rdata_q.recalls + CNT_W'(1);

	// Read address: scan pointer, shift pointer, or the command's index.
	always_comb begin
		unique case (state_q)
			S_SCAN:  raddr = p_q[AW-1:0];
			S_SHIFT: raddr = r_q[AW-1:0];
			default: raddr = idx_q;
		endcase
	end

	// Write port: shift move, append of the new record, or recall update.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = rdata_q;
		priority if (wv_s1) begin
			mem_we = 1'b1;
			mem_wa = wa_s1;
		end else if (state_q == S_APPEND && count_q < cap_eff) begin
			mem_we = 1'b1;
			mem_wa = count_q[AW-1:0];
			mem_wd = '{owner_id: new_id_q, observed_time: new_obs_q,
				recalls: '0, last_recall: '0};
		end else if (state_q == S_RCL) begin
			mem_we = 1'b1;
			mem_wd = '{owner_id: rdata_q.owner_id, observed_time: rdata_q.observed_time,
				recalls: cnt_inc, last_recall: rtime_q};
		end
	end

	// Record memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[mem_wa] <= mem_wd;
		end
		rdata_q <= store_q[raddr];
	end

	// Sequencer, working registers and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			evict_q     <= '0;
			cmd_q       <= CMD_INSERT;
			idx_q       <= '0;
			rd_hit_q    <= 1'b0;
			did_ev_q    <= 1'b0;
			status_q    <= ST_OK;
			new_id_q    <= '0;
			new_obs_q   <= '0;
			rtime_q     <= '0;
			p_q         <= '0;
			r_q         <= '0;
			cv_s1       <= 1'b0;
			ci_s1       <= '0;
			wv_s1       <= 1'b0;
			wa_s1       <= '0;
			best_key_q  <= '0;
			victim_q    <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end

			// Scan compare stage works in the cycle after the scan read.
			cv_s1 <= (state_q == S_SCAN);
			ci_s1 <= p_q[AW-1:0];
			if (scan_win) begin
				best_key_q <= key_rd;
				victim_q   <= ci_s1;
			end

			// Shift write stage works in the cycle after the shift read.
			wv_s1 <= (state_q == S_SHIFT) && (r_q < count_q);
			wa_s1 <= r_prev[AW-1:0];

			// Output valid: loading a new result wins over taking the old one.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						cmd_q     <= req.cmd;
						idx_q     <= AW'(req.entry_index);
						new_id_q  <= req.new_ledger_id;
						new_obs_q <= req.new_observed_time;
						rtime_q   <= req.recall_time;
						status_q  <= ST_OK;
						did_ev_q  <= 1'b0;
						rd_hit_q  <= 1'b0;
						p_q       <= '0;
						unique case (req.cmd)
							CMD_INSERT: begin
								state_q <= (count_q >= cap_eff) ? S_SCAN : S_APPEND;
							end
							CMD_RECALL, CMD_READ: begin
								if (idx_ok) begin
									rd_hit_q <= (req.cmd == CMD_READ);
									state_q  <= S_FETCH;
								end else begin
									status_q <= ST_NOT_FOUND;
									state_q  <= S_DONE;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_FETCH: begin
					state_q <= (cmd_q == CMD_RECALL) ? S_RCL : S_DONE;
				end
				S_RCL: begin
					state_q <= S_DONE;
				end
				S_SCAN: begin
					p_q <= p_q + CW'(1);
					if ((p_q + CW'(1)) == count_q) begin
						state_q <= S_SCEND;
					end
				end
				S_SCEND: begin
					r_q     <= CW'(victim_nx) + CW'(1);
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (r_q < count_q) begin
						r_q <= r_q + CW'(1);
					end else begin
						state_q <= S_SHEND;
					end
				end
				S_SHEND: begin
					count_q  <= count_q - CW'(1);
					did_ev_q <= 1'b1;
					if (evict_q != CNT_SAT) begin
						evict_q <= evict_q + CNT_W'(1);
					end
					state_q <= S_APPEND;
				end
				S_APPEND: begin
					if (count_q < cap_eff) begin
						count_q <= count_q + CW'(1);
					end else begin
						status_q <= ST_NO_ROOM;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_q.status               <= status_q;
						out_q.did_evict            <= did_ev_q;
						out_q.evicted_ledger_id    <= did_ev_q ? best_key_q[ID_W-1:0] : '0;
						out_q.stored_count         <= STORED_W'(count_q);
						out_q.entry_ledger_id      <= rd_hit_q ? rdata_q.owner_id : '0;
						out_q.entry_observed_time  <= rd_hit_q ? rdata_q.observed_time : '0;
						out_q.entry_recall_count   <= rd_hit_q ? rdata_q.recalls : '0;
						out_q.entry_last_recall    <= rd_hit_q ? rdata_q.last_recall : '0;
						out_q.total_evictions      <= evict_q;
						state_q                    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Channel outputs.
	assign req.ready               = (state_q == S_IDLE);
	assign rsp.valid               = out_valid_q;
	assign rsp.status              = out_q.status;
	assign rsp.did_evict           = out_q.did_evict;
	assign rsp.evicted_ledger_id   = out_q.evicted_ledger_id;
	assign rsp.stored_count        = out_q.stored_count;
	assign rsp.entry_ledger_id     = out_q.entry_ledger_id;
	assign rsp.entry_observed_time = out_q.entry_observed_time;
	assign rsp.entry_recall_count  = out_q.entry_recall_count;
	assign rsp.entry_last_recall   = out_q.entry_last_recall;
	assign rsp.total_evictions     = out_q.total_evictions;

`ifndef SYNTHESIS
	// The fill never exceeds the store size.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("stored count exceeds store size");

	// The chosen victim lies inside the filled part of the store.
	a_victim_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCEND) |=> (CW'(victim_q) < count_q))
		else $error("victim index outside stored entries");

	// A shift move only writes below the last filled place.
	a_shift_target: assert property (@(posedge clk) disable iff (!arst_n)
		wv_s1 |-> ((CW'(wa_s1) + CW'(1)) < count_q))
		else $error("shift write beyond stored entries");

	// Closing an eviction removes exactly one record.
	a_evict_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHEND) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("eviction did not remove one record");

	// The eviction counter never goes down.
	a_evict_mono: assert property (@(posedge clk) disable iff (!arst_n)
		evict_q >= $past(evict_q))
		else $error("eviction counter decreased");
`endif

endmodule

FILE: tb/esle_tb_pkg.sv
// Scoreboard for the episode store testbench: a bit-accurate predictor and a result checker.
// Depends on esle_pkg for the command and status codes, the record type and the result word.
package esle_tb_pkg;
	import esle_pkg::*;

	localparam int DEPTH = 64;

	// The one command value the block leaves unused.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// One request word as the driver offers it.
	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [IDX_W-1:0]  entry_index;
		logic [ID_W-1:0]   new_ledger_id;
		logic [TIME_W-1:0] new_observed_time;
		logic [TIME_W-1:0] recall_time;
	} episode_cmd_t;

	class episode_scoreboard;
		episode_t          slots[DEPTH];
		int unsigned       held;
		logic [CNT_W-1:0]  evictions;
		logic [CAP_W-1:0]  capacity;
		result_t           awaited[$];
		int unsigned       errors;
		int unsigned       checked;
		int unsigned       n_evict;
		int unsigned       n_no_room;
		int unsigned       n_not_found;

		function new();
			held      = 0;
			evictions = '0;
			capacity  = CAP_RESET;
			errors    = 0;
			checked   = 0;
			n_evict   = 0;
			n_no_room = 0;
			n_not_found = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] value);
			capacity = value;
		endfunction

		// Zero behaves as one, anything above the store depth as the depth.
		function int unsigned live_capacity();
			if (capacity == 0)
				return 1;
			if (capacity > DEPTH)
				return DEPTH;
			return capacity;
		endfunction

		// Least recalled first, then oldest, then smallest ledger id; lowest index on a tie.
		function int unsigned least_recalled();
			int unsigned pick;
			pick = 0;
			for (int unsigned i = 1; i < held; i++) begin
				if (slots[i].recalls != slots[pick].recalls) begin
					if (slots[i].recalls < slots[pick].recalls)
						pick = i;
				end else if (slots[i].observed_time != slots[pick].observed_time) begin
					if (slots[i].observed_time < slots[pick].observed_time)
						pick = i;
				end else if (slots[i].owner_id < slots[pick].owner_id) begin
					pick = i;
				end
			end
			return pick;
		endfunction

		function bit idle();
			return awaited.size() == 0;
		endfunction

		// Apply one accepted command to the predicted store and queue its result word.
		function void note_command(episode_cmd_t w);
			result_t     r;
			int unsigned cap;
			int unsigned victim;
			r = '0;
			case (w.cmd)
				CMD_INSERT: begin
					cap = live_capacity();
					if (held >= cap && held > 0) begin
						victim = least_recalled();
						r.did_evict = 1'b1;
						r.evicted_ledger_id = slots[victim].owner_id;
						for (int unsigned i = victim; i + 1 < held; i++)
							slots[i] = slots[i + 1];
						held--;
						if (evictions != CNT_SAT)
							evictions++;
						n_evict++;
					end
					if (held + 1 > cap || held >= DEPTH) begin
						r.status = ST_NO_ROOM;
						n_no_room++;
					end else begin
						slots[held] = '{owner_id: w.new_ledger_id,
							observed_time: w.new_observed_time,
							recalls: '0, last_recall: '0};
						held++;
					end
				end
				CMD_RECALL, CMD_READ: begin
					if (w.entry_index >= held) begin
						r.status = ST_NOT_FOUND;
						n_not_found++;
					end else if (w.cmd == CMD_RECALL) begin
						if (slots[w.entry_index].recalls != CNT_SAT)
							slots[w.entry_index].recalls++;
						slots[w.entry_index].last_recall = w.recall_time;
					end else begin
						r.entry_ledger_id     = slots[w.entry_index].owner_id;
						r.entry_observed_time = slots[w.entry_index].observed_time;
						r.entry_recall_count  = slots[w.entry_index].recalls;
						r.entry_last_recall   = slots[w.entry_index].last_recall;
					end
				end
				default: ;
			endcase
			r.stored_count    = STORED_W'(held);
			r.total_evictions = evictions;
			awaited.push_back(r);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		// Match one result word against the oldest outstanding prediction.
		function void check_result(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				$error("result word arrived with no command outstanding");
				errors++;
				return;
			end
			want = awaited.pop_front();
			checked++;
			compare_field("status", want.status, got.status);
			compare_field("did_evict", want.did_evict, got.did_evict);
			compare_field("evicted_ledger_id", want.evicted_ledger_id, got.evicted_ledger_id);
			compare_field("stored_count", want.stored_count, got.stored_count);
			compare_field("entry_ledger_id", want.entry_ledger_id, got.entry_ledger_id);
			compare_field("entry_observed_time", want.entry_observed_time,
				got.entry_observed_time);
			compare_field("entry_recall_count", want.entry_recall_count,
				got.entry_recall_count);
			compare_field("entry_last_recall", want.entry_last_recall, got.entry_last_recall);
			compare_field("total_evictions", want.total_evictions, got.total_evictions);
		endfunction
	endclass

endpackage

FILE: tb/episode_store_least_recalled_evict_tb.sv
// Top-level testbench for the episode store: clock, reset, request driver, response sink.
// Depends on esle_pkg, the channel interfaces in esle_if.sv and the scoreboard in esle_tb_pkg.
module episode_store_least_recalled_evict_tb;
	import esle_pkg::*;
	import esle_tb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASES      = 12;
	localparam logic [ID_W-1:0] ALL_ONES = '1;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CAP_W-1:0] cfg_wr_data;

	// Flags shared between the stimulus and the response sink; a count of capacity settings.
	bit steady;
	bit hold_rsp;
	int settings_used;

	esle_req_if req_ch();
	esle_rsp_if rsp_ch();

	episode_scoreboard book = new();

	// Capacity and length of each random phase; zero and values past the depth included.
	int phase_cap[PHASES] = '{4, 2, 64, 6, 0, 12, 3, 1, 127, 8, 2, 5};
	int phase_len[PHASES] = '{50, 40, 130, 50, 20, 60, 30, 20, 60, 50, 30, 40};

	episode_store_least_recalled_evict u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic episode_cmd_t make_cmd(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
		logic [ID_W-1:0] id, logic [TIME_W-1:0] obs, logic [TIME_W-1:0] rt);
		episode_cmd_t c;
		c.cmd               = cmd;
		c.entry_index       = idx;
		c.new_ledger_id     = id;
		c.new_observed_time = obs;
		c.recall_time       = rt;
		return c;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly valid indexes, insert_pct% inserts; small pools make victim-search ties likely.
	function automatic episode_cmd_t random_command(int insert_pct);
		episode_cmd_t c;
		int           roll;
		roll = $urandom_range(99);
		c = make_cmd(CMD_INSERT, IDX_W'($urandom_range(63)), rand64(), rand64(), rand64());
		if (($urandom_range(99) < 90) && book.held > 0)
			c.entry_index = IDX_W'($urandom_range(book.held - 1));
		if ($urandom_range(99) < 30)
			c.new_ledger_id = ID_W'($urandom_range(3));
		if ($urandom_range(99) < 30)
			c.new_observed_time = TIME_W'($urandom_range(3));
		if (roll < insert_pct)
			c.cmd = CMD_INSERT;
		else if (roll < insert_pct + (95 - insert_pct) / 2)
			c.cmd = CMD_RECALL;
		else if (roll < 95)
			c.cmd = CMD_READ;
		else
			c.cmd = CMD_UNUSED;
		return c;
	endfunction

	// Offer one word, with random gaps before it unless steady, and record it once taken.
	task automatic issue_command(episode_cmd_t c);
		while (!steady && $urandom_range(99) < 13) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid             <= 1'b1;
		req_ch.cmd               <= c.cmd;
		req_ch.entry_index       <= c.entry_index;
		req_ch.new_ledger_id     <= c.new_ledger_id;
		req_ch.new_observed_time <= c.new_observed_time;
		req_ch.recall_time       <= c.recall_time;
		do
			@(posedge clk);
		while (!req_ch.ready);
		book.note_command(c);
	endtask

	// Stop offering and wait until every predicted word has come back.
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (!book.idle())
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		book.set_capacity(value);
		settings_used++;
	endtask

	// Response sink: random stalls unless steady, plus a long hold-off when hold_rsp is set.
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
			end else begin
				rsp_ch.ready <= steady || ($urandom_range(99) >= 13);
				@(posedge clk);
			end
		end
	end

	// Every accepted result word goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			book.check_result(result_t'{status: rsp_ch.status,
				did_evict: rsp_ch.did_evict,
				evicted_ledger_id: rsp_ch.evicted_ledger_id,
				stored_count: rsp_ch.stored_count,
				entry_ledger_id: rsp_ch.entry_ledger_id,
				entry_observed_time: rsp_ch.entry_observed_time,
				entry_recall_count: rsp_ch.entry_recall_count,
				entry_last_recall: rsp_ch.entry_last_recall,
				total_evictions: rsp_ch.total_evictions});
	end

	// Watchdog: too long without a word moving on either channel ends the run.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		episode_cmd_t c;
		steady                   = 1'b0;
		hold_rsp                 = 1'b0;
		settings_used            = 0;
		arst_n                   = 1'b0;
		cfg_wr_en                = 1'b0;
		cfg_wr_data              = '0;
		req_ch.valid             = 1'b0;
		req_ch.cmd               = CMD_INSERT;
		req_ch.entry_index       = '0;
		req_ch.new_ledger_id     = '0;
		req_ch.new_observed_time = '0;
		req_ch.recall_time       = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty store, bad indexes, the unused command, field extremes.
		write_capacity(CAP_W'(3));
		issue_command(make_cmd(CMD_READ, '0, '0, '0, '0));
		issue_command(make_cmd(CMD_RECALL, '1, '0, '0, ALL_ONES));
		issue_command(make_cmd(CMD_UNUSED, '1, ALL_ONES, ALL_ONES, ALL_ONES));
		issue_command(make_cmd(CMD_INSERT, '0, ALL_ONES, ALL_ONES, '0));
		issue_command(make_cmd(CMD_INSERT, '0, '0, '0, '0));
		issue_command(make_cmd(CMD_INSERT, '0, 64'd5, '0, '0));
		issue_command(make_cmd(CMD_RECALL, 6'd0, '0, '0, ALL_ONES));
		issue_command(make_cmd(CMD_RECALL, 6'd2, '0, '0, 64'h0123_4567_89ab_cdef));
		issue_command(make_cmd(CMD_READ, 6'd0, '0, '0, '0));
		issue_command(make_cmd(CMD_READ, 6'd1, '0, '0, '0));
		issue_command(make_cmd(CMD_READ, 6'd2, '0, '0, '0));
		issue_command(make_cmd(CMD_READ, 6'd3, '0, '0, '0));
		// Full store: the never-recalled entry goes first.
		issue_command(make_cmd(CMD_INSERT, '0, 64'd7, 64'd9, '0));
		issue_command(make_cmd(CMD_RECALL, 6'd2, '0, '0, 64'd1));
		// All counts equal now, so the oldest entry goes.
		issue_command(make_cmd(CMD_INSERT, '0, 64'd2, 64'd9, '0));
		issue_command(make_cmd(CMD_READ, 6'd2, '0, '0, '0));

		// Capacity lowered below the fill: every insert evicts one; only the third is kept.
		write_capacity(CAP_W'(1));
		repeat (3) issue_command(make_cmd(CMD_INSERT, '0, rand64(), rand64(), '0));
		// Zero acts as one.
		write_capacity(CAP_W'(0));
		issue_command(make_cmd(CMD_INSERT, '0, 64'd3, 64'd3, '0));
		// Values past the depth act as the depth.
		write_capacity('1);
		issue_command(make_cmd(CMD_READ, 6'd0, '0, '0, '0));

		// Random phases, one capacity setting each.
		for (int p = 0; p < PHASES; p++) begin
			write_capacity(CAP_W'(phase_cap[p]));
			steady = (p == 5);
			for (int k = 0; k < phase_len[p]; k++) begin
				if ((p == 3 || p == 10) && k == 10)
					hold_rsp = 1'b1;
				c = random_command((phase_cap[p] >= 64) ? 70 : 45);
				issue_command(c);
			end
		end
		steady = 1'b0;

		settle();
		repeat (150) @(posedge clk);
		$display("Checked %0d result words over %0d capacity settings.",
			book.checked, settings_used);
		$display("Saw %0d evictions, %0d dropped inserts and %0d bad-index requests.",
			book.n_evict, book.n_no_room, book.n_not_found);
		if (book.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
